### rtl/lmlt_pkg.sv
// Shared types and timing constants for the LCD mode and line timer.
`timescale 1ns / 1ps

package lmlt_pkg;

	// Display modes as reported on the mode port.
	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} mode_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_DISPLAY_ENABLE = 2'd0;
	localparam logic [1:0] CFG_COMPARE_LINE   = 2'd1;
	localparam logic [1:0] CFG_STAT_ENABLES   = 2'd2;

	// Dot-clock thresholds for each phase of a line.
	localparam logic [9:0] OAM_TICKS    = 10'd80;
	localparam logic [9:0] XFER_TICKS   = 10'd172;
	localparam logic [9:0] HBLANK_TICKS = 10'd204;
	localparam logic [9:0] LINE_TICKS   = 10'd456;

	localparam logic [7:0] VBLANK_FIRST_LINE = 8'd144;
	localparam logic [7:0] LAST_LINE         = 8'd153;

	// Status interrupt source enable bits.
	localparam int EN_HBLANK = 0;
	localparam int EN_VBLANK = 1;
	localparam int EN_OAM    = 2;
	localparam int EN_MATCH  = 3;

	typedef struct packed {
		logic       display_enable;
		logic [7:0] compare_line;
		logic [3:0] stat_enables;
	} cfg_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] line;
		logic       line_match;
		logic       vblank_request;
		logic       stat_request;
		logic       render_line;
	} result_t;

endpackage

### rtl/lmlt_timer.sv
// Mode and line state of the timer and its single-pass step logic.
`timescale 1ns / 1ps

module lmlt_timer import lmlt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       step,
	input  logic [7:0] tick_count,
	output result_t    result
);

	mode_t      mode_q, mode_d;
	logic [9:0] acc_q, acc_d;
	logic [7:0] line_q, line_d;
	logic       match_q, match_d;
	logic [9:0] acc_sum;
	logic [7:0] line_inc;
	logic       vblank_req, stat_req, render;

	// the accumulator is 10 bits wide, wide enough that the sum never wraps
	assign acc_sum  = acc_q + {2'b00, tick_count};
	assign line_inc = line_q + 8'd1;

	always_comb begin
		mode_d     = mode_q;
		acc_d      = acc_q;
		line_d     = line_q;
		match_d    = match_q;
		vblank_req = 1'b0;
		stat_req   = 1'b0;
		render     = 1'b0;
		if (cfg.display_enable) begin
			acc_d = acc_sum;
			case (mode_q)
				MODE_OAM: begin
					if (acc_sum >= OAM_TICKS) begin
						acc_d  = '0;
						mode_d = MODE_XFER;
					end
				end
				MODE_XFER: begin
					if (acc_sum >= XFER_TICKS) begin
						acc_d    = '0;
						render   = 1'b1;
						stat_req = cfg.stat_enables[EN_HBLANK];
						mode_d   = MODE_HBLANK;
					end
				end
				MODE_HBLANK: begin
					if (acc_sum >= HBLANK_TICKS) begin
						acc_d   = '0;
						line_d  = line_inc;
						match_d = (line_inc == cfg.compare_line);
						if (line_inc == VBLANK_FIRST_LINE) begin
							vblank_req = 1'b1;
							stat_req   = (match_d & cfg.stat_enables[EN_MATCH]) |
								cfg.stat_enables[EN_VBLANK];
							mode_d     = MODE_VBLANK;
						end else begin
							stat_req = (match_d & cfg.stat_enables[EN_MATCH]) |
								cfg.stat_enables[EN_OAM];
							mode_d   = MODE_OAM;
						end
					end
				end
				default: begin
					if (acc_sum >= LINE_TICKS) begin
						acc_d  = '0;
						line_d = line_inc;
						// wrap past the last vblank line and restart the frame
						if (line_inc > LAST_LINE) begin
							line_d   = '0;
							match_d  = (cfg.compare_line == 8'd0);
							stat_req = (match_d & cfg.stat_enables[EN_MATCH]) |
								cfg.stat_enables[EN_OAM];
							mode_d   = MODE_OAM;
						end
					end
				end
			endcase
		end
	end

	assign result = '{
		mode:           mode_d,
		line:           line_d,
		line_match:     match_d,
		vblank_request: vblank_req,
		stat_request:   stat_req,
		render_line:    render
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_XFER;
			acc_q   <= '0;
			line_q  <= '0;
			match_q <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_d;
			acc_q   <= acc_d;
			line_q  <= line_d;
			match_q <= match_d;
		end
	end

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_q <= LAST_LINE) else $error("line counter beyond last line");

	a_disabled_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && !cfg.display_enable |=> $stable(mode_q) && $stable(line_q) && $stable(acc_q))
		else $error("state changed while display disabled");

	a_acc_below_line: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q < LINE_TICKS) else $error("tick accumulator past line length");

endmodule

### rtl/lcd_mode_and_line_timer_top.sv
// Top level of the LCD mode and line timer: configuration registers and output buffering.
`timescale 1ns / 1ps

// LCD mode and line timer. Each transfer on the input channel carries the
// number of dot-clock ticks elapsed since the previous one; while the
// display is enabled the block accumulates them and walks each line through
// OAM search (80 ticks), pixel transfer (172) and hblank (204), with lines
// 144..153 spent in vblank (456 ticks each). At most one phase boundary is
// taken per item and leftover ticks past a boundary are dropped. Every input
// item yields exactly one result: the mode and line after the step, the held
// line-coincidence flag, and the vblank, status and render-line pulses.
// Throughput is one item per clock while in_stall is low, and each result
// is registered on its way out. The step is a single add-and-compare
// against the mode threshold between the state registers and the output
// register, and a one-entry skid register behind the output register lets
// the input keep flowing for one extra item while a result waits; in_stall
// rises only when that skid entry is full. Configuration writes are always
// taken (cfg_ready is tied high) and should be issued only while idle.
// Register index 0 is display_enable, 1 compare_line, 2 stat_enables;
// index 3 is ignored. Reset puts the block in pixel transfer on line 0.

module lcd_mode_and_line_timer_top import lmlt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// input item channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] tick_count,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] mode,
	output logic [7:0] line,
	output logic       line_match,
	output logic       vblank_request,
	output logic       stat_request,
	output logic       render_line,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cfg_t    cfg_q;
	result_t step_result;
	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;
	logic    in_xfer, out_xfer, cfg_xfer;

	// Configuration is always accepted.
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_xfer) begin
			case (cfg_index)
				CFG_DISPLAY_ENABLE: cfg_q.display_enable <= cfg_data[0];
				CFG_COMPARE_LINE:   cfg_q.compare_line   <= cfg_data;
				CFG_STAT_ENABLES:   cfg_q.stat_enables   <= cfg_data[3:0];
				default: ;  // unmapped index: drop the write
			endcase
		end
	end

	// Stall the producer only when the skid entry is occupied.
	assign in_stall = skid_valid_q;
	assign in_xfer  = in_valid & ~in_stall;
	assign out_xfer = out_valid_q & ~out_stall;

	lmlt_timer u_timer (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.step       (in_xfer),
		.tick_count (tick_count),
		.result     (step_result)
	);

	// Output register plus one skid entry. When the output slot frees up,
	// refill it from the skid first, otherwise from the new item; when the
	// output is held, park a new item in the skid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_xfer) begin
				out_valid_q  <= skid_valid_q | in_xfer;
				skid_valid_q <= 1'b0;
			end else if (in_xfer) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_xfer) begin
			out_q <= skid_valid_q ? skid_q : step_result;
		end
		if (in_xfer && out_valid_q && !out_xfer) begin
			skid_q <= step_result;
		end
	end

	assign out_valid      = out_valid_q;
	assign mode           = out_q.mode;
	assign line           = out_q.line;
	assign line_match     = out_q.line_match;
	assign vblank_request = out_q.vblank_request;
	assign stat_request   = out_q.stat_request;
	assign render_line    = out_q.render_line;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q) else $error("skid entry held with empty output");

	a_render_hblank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.render_line |-> out_q.mode == MODE_HBLANK)
		else $error("render pulse outside hblank entry");

	a_vblank_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.vblank_request |->
		out_q.mode == MODE_VBLANK && out_q.line == VBLANK_FIRST_LINE)
		else $error("vblank request away from first vblank line");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_xfer |=> out_valid_q && !skid_valid_q)
		else $error("skid entry not moved to output");

endmodule

### tb/sv/lcd_mode_and_line_timer_top_tb.sv
// Self-checking testbench for the LCD mode and line timer top level.
`timescale 1ns / 1ps

// Tick transfers go in through a queue-fed driver. A line-timing predictor
// inside the bench works out the expected status for each accepted transfer.
// A monitor compares every result transfer with the oldest expected status.
// Register writes happen only while the block is drained: once after reset,
// and again between random phases.

module lcd_mode_and_line_timer_top_tb;
	import lmlt_pkg::*;

	localparam logic [1:0] CFG_UNUSED  = 2'd3;  // index past the register list
	localparam int         QUIET_LIMIT = 2000;  // cycles with no transfer at all
	localparam int         PHASES      = 8;
	localparam int         PHASE_ITEMS = 235;

	// Hold every input at a known value from time zero.
	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic [7:0] tick_count = '0;
	logic       out_stall  = 1'b0;
	logic       cfg_valid  = 1'b0;
	logic [1:0] cfg_index  = '0;
	logic [7:0] cfg_data   = '0;
	logic       in_stall;
	logic       out_valid;
	logic       cfg_ready;
	logic [1:0] mode;
	logic [7:0] line;
	logic       line_match;
	logic       vblank_request;
	logic       stat_request;
	logic       render_line;

	// Predictor copy of the register file and of the timing state. The block
	// comes out of reset in pixel transfer on line 0 with all registers clear.
	cfg_t       timer_cfg   = '0;
	mode_t      lcd_mode    = MODE_XFER;
	logic [9:0] dot_acc     = '0;
	logic [7:0] scan_line   = '0;
	logic       coincidence = 1'b0;

	logic [7:0] tick_q[$];             // tick counts still to be offered
	result_t    expected_status_q[$];  // predicted status, oldest first

	int items_total  = 0;
	int results_done = 0;
	int fail_count   = 0;
	int quiet_cycles = 0;
	int send_wait    = 0;
	int recv_wait    = 0;
	int hold_left    = 0;
	bit send_steady  = 1'b0;
	bit recv_steady  = 1'b0;

	lcd_mode_and_line_timer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.tick_count    (tick_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.mode          (mode),
		.line          (line),
		.line_match    (line_match),
		.vblank_request(vblank_request),
		.stat_request  (stat_request),
		.render_line   (render_line),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Refresh the coincidence flag; return whether it raises a status request.
	function automatic logic line_compare();
		coincidence = (scan_line == timer_cfg.compare_line);
		return coincidence && timer_cfg.stat_enables[EN_MATCH];
	endfunction

	// Advance the line timer by one tick transfer and return the status it reports.
	// Only one phase boundary is taken per transfer; leftover ticks are dropped.
	function automatic result_t advance_timer(input logic [7:0] ticks);
		result_t res;
		res = '0;
		if (timer_cfg.display_enable) begin
			dot_acc = dot_acc + {2'b00, ticks};
			case (lcd_mode)
				MODE_OAM: begin
					if (dot_acc >= OAM_TICKS) begin
						dot_acc  = '0;
						lcd_mode = MODE_XFER;
					end
				end
				MODE_XFER: begin
					if (dot_acc >= XFER_TICKS) begin
						dot_acc          = '0;
						res.render_line  = 1'b1;
						res.stat_request = timer_cfg.stat_enables[EN_HBLANK];
						lcd_mode         = MODE_HBLANK;
					end
				end
				MODE_HBLANK: begin
					if (dot_acc >= HBLANK_TICKS) begin
						dot_acc   = '0;
						scan_line = scan_line + 8'd1;
						if (line_compare())
							res.stat_request = 1'b1;
						// The last visible line hands over to vblank instead of OAM search.
						if (scan_line == VBLANK_FIRST_LINE) begin
							res.vblank_request = 1'b1;
							if (timer_cfg.stat_enables[EN_VBLANK])
								res.stat_request = 1'b1;
							lcd_mode = MODE_VBLANK;
						end else begin
							if (timer_cfg.stat_enables[EN_OAM])
								res.stat_request = 1'b1;
							lcd_mode = MODE_OAM;
						end
					end
				end
				default: begin
					if (dot_acc >= LINE_TICKS) begin
						dot_acc   = '0;
						scan_line = scan_line + 8'd1;
						// Vblank lines skip the coincidence check; only the wrap to 0 does it.
						if (scan_line > LAST_LINE) begin
							scan_line = '0;
							if (line_compare())
								res.stat_request = 1'b1;
							if (timer_cfg.stat_enables[EN_OAM])
								res.stat_request = 1'b1;
							lcd_mode = MODE_OAM;
						end
					end
				end
			endcase
		end
		res.mode       = lcd_mode;
		res.line       = scan_line;
		res.line_match = coincidence;
		return res;
	endfunction

	function automatic void check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endfunction

	// Tick driver: predict on every accepted transfer, then either hold a stalled
	// item, idle for the drawn number of cycles, or offer the next queued item.
	always @(posedge clk or negedge arst_n) begin : tick_driver
		if (!arst_n) begin
			in_valid   <= 1'b0;
			tick_count <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_status_q.push_back(advance_timer(tick_count));
				// Switch now and then between gap-free bursts and random gaps.
				if ($urandom_range(0, 49) == 0)
					send_steady = !send_steady;
				send_wait = send_steady ? 0 : $urandom_range(0, 19);
			end
			if (!in_valid || !in_stall) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (tick_q.size() > 0) begin
					tick_count <= tick_q.pop_front();
					in_valid   <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Status monitor: check each result transfer against the oldest prediction,
	// then draw the stall for the next one. Twice during the run, hold off for a
	// long stretch so the skid entry fills and the block stalls its input.
	always @(posedge clk or negedge arst_n) begin : status_monitor
		result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_status_q.size() == 0) begin
					$error("status transfer with no prediction waiting: mode %0d line %0d",
						mode, line);
					fail_count++;
				end else begin
					want = expected_status_q.pop_front();
					check_field("mode", want.mode, mode);
					check_field("line", want.line, line);
					check_field("line_match", want.line_match, line_match);
					check_field("vblank_request", want.vblank_request, vblank_request);
					check_field("stat_request", want.stat_request, stat_request);
					check_field("render_line", want.render_line, render_line);
				end
				results_done++;
				if ($urandom_range(0, 49) == 0)
					recv_steady = !recv_steady;
				recv_wait = recv_steady ? 0 : $urandom_range(0, 19);
				if (results_done == 600 || results_done == 1400)
					hold_left = 150 + $urandom_range(0, 100);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (recv_wait > 0) begin
				recv_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: end the run once no channel has moved for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("lcd_mode_and_line_timer_top_tb failed");
			$finish;
		end
	end

	// Write one register and mirror the masked value into the predictor copy.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_DISPLAY_ENABLE: timer_cfg.display_enable = data[0];
			CFG_COMPARE_LINE:   timer_cfg.compare_line   = data;
			CFG_STAT_ENABLES:   timer_cfg.stat_enables   = data[3:0];
			default: ;
		endcase
	endtask

	// Call only right after a falling edge so the driver never races the push.
	task automatic queue_tick(input logic [7:0] ticks);
		tick_q.push_back(ticks);
		items_total++;
	endtask

	// Wait until every queued item has produced its status, then let the
	// pipeline settle before touching the registers.
	task automatic drain();
		do @(negedge clk); while (results_done < items_total);
		repeat (4) @(posedge clk);
	endtask

	initial begin : test_sequence
		logic [7:0] cmp_pick;
		logic [3:0] en_pick;
		int         roll;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Display off out of reset: ticks must change nothing.
		@(negedge clk);
		queue_tick(8'd255);
		queue_tick(8'd0);
		queue_tick(8'd170);
		drain();

		// Enable with junk in the upper data bits to exercise masking; poke the
		// unused index once.
		write_reg(CFG_DISPLAY_ENABLE, 8'hFF);
		write_reg(CFG_COMPARE_LINE, 8'd1);
		write_reg(CFG_STAT_ENABLES, 8'hFF);
		write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));

		// Walk one line by hand: exact thresholds, one-short, and large excess.
		@(negedge clk);
		queue_tick(8'd0);
		queue_tick(8'd171);
		queue_tick(8'd1);    // transfer ends exactly at 172
		queue_tick(8'd203);
		queue_tick(8'd1);    // hblank ends exactly at 204, line 1 matches
		queue_tick(8'd79);
		queue_tick(8'd1);    // OAM search ends exactly at 80
		queue_tick(8'd255);  // transfer ends with excess dropped
		queue_tick(8'd255);  // hblank ends, line 2 no longer matches
		queue_tick(8'd255);
		queue_tick(8'd0);
		queue_tick(8'd255);
		drain();

		// Random phases, each with fresh register settings. One phase runs with
		// the display off to check that the timing state holds.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: cmp_pick = 8'd0;
				1: cmp_pick = 8'd255;
				2: cmp_pick = VBLANK_FIRST_LINE;
				3: cmp_pick = LAST_LINE;
				default: cmp_pick = 8'($urandom_range(0, 153));
			endcase
			case (p)
				0: en_pick = 4'h0;
				1: en_pick = 4'hF;
				default: en_pick = 4'($urandom_range(0, 15));
			endcase
			write_reg(CFG_DISPLAY_ENABLE, {7'($urandom_range(0, 127)), (p != 4)});
			write_reg(CFG_COMPARE_LINE, cmp_pick);
			write_reg(CFG_STAT_ENABLES, {4'($urandom_range(0, 15)), en_pick});

			@(negedge clk);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				roll = $urandom_range(0, 19);
				if (roll < 14)
					queue_tick(8'($urandom_range(0, 255)));
				else if (roll < 17)
					queue_tick(8'($urandom_range(0, 15)));
				else if (roll < 19)
					queue_tick(8'd255);
				else
					queue_tick(8'd0);
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (expected_status_q.size() != 0) begin
			$error("%0d predicted status transfers never arrived", expected_status_q.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("lcd_mode_and_line_timer_top_tb passed");
		else
			$display("lcd_mode_and_line_timer_top_tb failed");
		$finish;
	end

endmodule
